[hw/rtl/pbrs_pkg.sv]
// ----------------------------------------------------------------------------
// pbrs_pkg: shared types and constants for the parking brake rate select
// Holds register codes, stop kinds, fixed brake constants and the records
// passed between the front stages, the square-root cells and the top level.
// ----------------------------------------------------------------------------
package pbrs_pkg;

  // Register codes (byte address = 4 * code)
  localparam logic [2:0] REG_PARA_A          = 3'd0;
  localparam logic [2:0] REG_PARA_B          = 3'd1;
  localparam logic [2:0] REG_AUTO_REVERSAL_B = 3'd2;
  localparam logic [2:0] REG_REVERSAL_B      = 3'd3;
  localparam logic [2:0] REG_GARAGE_ACC      = 3'd4;
  localparam logic [2:0] REG_ORIGIN_CAP_ACC  = 3'd5;
  localparam logic [2:0] REG_DEFAULT_ACC     = 3'd6;
  localparam logic [2:0] REG_MODE_FLAGS      = 3'd7;

  // Stop-point kinds
  localparam logic [1:0] KIND_NORMAL       = 2'd0;
  localparam logic [1:0] KIND_AUTO_REVERSAL = 2'd1;
  localparam logic [1:0] KIND_GARAGE       = 2'd2;
  localparam logic [1:0] KIND_REVERSAL     = 2'd3;

  // Mode flag bit positions
  localparam int MODE_RAIN     = 0;
  localparam int MODE_RAIN_PID = 1;
  localparam int MODE_IMM_STOP = 2;

  // Fixed brake constants
  localparam logic [10:0]        EMERGENCY_ACC  = 11'd150;
  localparam logic signed [24:0] REAR_STOP_DIST = 25'sd0;
  localparam logic [10:0]        REAR_STOP_ACC  = 11'd0;

  // Square-root datapath sizes: radicand 2*acc*dist < 2^34
  localparam int RAD_W   = 34;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int SQ_STEPS = ROOT_W;

  // Configuration registers
  typedef struct packed {
    logic [15:0] para_a;
    logic [10:0] para_b;
    logic [10:0] auto_reversal_b;
    logic [10:0] reversal_b;
    logic [9:0]  garage_acc;
    logic [9:0]  origin_cap_acc;
    logic [9:0]  default_acc;
    logic [2:0]  mode_flags;
  } cfg_t;

  // One input request
  typedef struct packed {
    logic [1:0]  stop_kind;
    logic [13:0] last_speed;
    logic [23:0] distance;
    logic        speed_target_ok;
    logic        speed_train_ok;
    logic        stopped;
    logic        coupled_rear;
  } in_item_t;

  // Side data riding along the square-root chain
  typedef struct packed {
    logic [10:0] acc;
    logic [13:0] speed;
    logic        go;
    logic        emerg;
  } sq_side_t;

  // State held by one square-root cell
  typedef struct packed {
    logic [RAD_W-1:0]  x;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    sq_side_t          side;
  } sq_t;

endpackage

[hw/rtl/parking_brake_rate_select.sv]
// ----------------------------------------------------------------------------
// parking_brake_rate_select: precise-stop brake rate selection
// Picks the candidate brake rate for the stop kind, forms the trigger speed
// sqrt(2*rate*distance) and decides whether the precise stop begins.
//
// Usage:
//   Input stream (in_*) carries one request per control period; the result
//   stream (out_*) returns one result per request, in order. The APB-style
//   cfg_* port sets the eight registers at byte addresses 0x00..0x1C; write
//   them only while no request is in flight.
//   From input accept to result valid a request passes three front
//   stages (speed multiply, rate selection, radicand multiply), seventeen
//   square-root cells of one root bit each, and the output register.
//   Throughput is one request per cycle unless the receiver stalls.
//   When the receiver stalls, the result holds in the output register and
//   requests pile up stage by stage; in_tready falls only once every stage
//   is full. Reset empties all stages and loads the register reset values
//   (origin_cap_acc = 1023, all others zero).
// ----------------------------------------------------------------------------
module parking_brake_rate_select import pbrs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [13:0] last_speed, [37:14] distance, [39:38] zero
  input  logic [5:0]  in_tuser,   // [1:0] stop_kind, [2] speed_target_ok,
                                  // [3] speed_train_ok, [4] stopped, [5] coupled_rear
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [10:0] brake_acc, [21:11] candidate_acc,
                                  // [39:22] trigger_speed
  output logic        out_tuser,  // [0] precise_stop
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t     cfg_r;
  in_item_t in_item;
  logic     wr_en;

  logic                front_valid;
  logic                front_ready;
  sq_t                 front_data;
  logic [SQ_STEPS:0]   chain_valid;
  logic [SQ_STEPS:0]   chain_ready;
  sq_t                 chain_data [SQ_STEPS+1];

  logic        out_valid_r, out_valid_nxt;
  logic [10:0] brake_r;
  logic [10:0] cand_r;
  logic [17:0] trig_r;
  logic        precise_r;

  sq_side_t    tail_side;
  logic [17:0] tail_trig;
  logic        tail_precise;
  logic [10:0] tail_cand;
  logic [10:0] tail_brake;

  // Register writes on the access phase
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.para_a          <= '0;
      cfg_r.para_b          <= '0;
      cfg_r.auto_reversal_b <= '0;
      cfg_r.reversal_b      <= '0;
      cfg_r.garage_acc      <= '0;
      cfg_r.origin_cap_acc  <= 10'd1023;
      cfg_r.default_acc     <= '0;
      cfg_r.mode_flags      <= '0;
    end else if (wr_en) begin
      case (cfg_paddr[4:2])
        REG_PARA_A:          cfg_r.para_a          <= cfg_pwdata[15:0];
        REG_PARA_B:          cfg_r.para_b          <= cfg_pwdata[10:0];
        REG_AUTO_REVERSAL_B: cfg_r.auto_reversal_b <= cfg_pwdata[10:0];
        REG_REVERSAL_B:      cfg_r.reversal_b      <= cfg_pwdata[10:0];
        REG_GARAGE_ACC:      cfg_r.garage_acc      <= cfg_pwdata[9:0];
        REG_ORIGIN_CAP_ACC:  cfg_r.origin_cap_acc  <= cfg_pwdata[9:0];
        REG_DEFAULT_ACC:     cfg_r.default_acc     <= cfg_pwdata[9:0];
        REG_MODE_FLAGS:      cfg_r.mode_flags      <= cfg_pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_paddr[4:2])
      REG_PARA_A:          cfg_prdata = 32'(cfg_r.para_a);
      REG_PARA_B:          cfg_prdata = 32'(cfg_r.para_b);
      REG_AUTO_REVERSAL_B: cfg_prdata = 32'(cfg_r.auto_reversal_b);
      REG_REVERSAL_B:      cfg_prdata = 32'(cfg_r.reversal_b);
      REG_GARAGE_ACC:      cfg_prdata = 32'(cfg_r.garage_acc);
      REG_ORIGIN_CAP_ACC:  cfg_prdata = 32'(cfg_r.origin_cap_acc);
      REG_DEFAULT_ACC:     cfg_prdata = 32'(cfg_r.default_acc);
      REG_MODE_FLAGS:      cfg_prdata = 32'(cfg_r.mode_flags);
      default:             cfg_prdata = '0;
    endcase
  end

  // Unpack the input request
  assign in_item.stop_kind       = in_tuser[1:0];
  assign in_item.last_speed      = in_tdata[13:0];
  assign in_item.distance        = in_tdata[37:14];
  assign in_item.speed_target_ok = in_tuser[2];
  assign in_item.speed_train_ok  = in_tuser[3];
  assign in_item.stopped         = in_tuser[4];
  assign in_item.coupled_rear    = in_tuser[5];

  pbrs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .up_valid   (in_tvalid),
    .up_ready   (in_tready),
    .up_item    (in_item),
    .down_valid (front_valid),
    .down_ready (front_ready),
    .down_data  (front_data)
  );

  assign chain_valid[0] = front_valid;
  assign chain_data[0]  = front_data;
  assign front_ready    = chain_ready[0];

  // Square-root chain, one root bit per cell
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    pbrs_sqrt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .up_valid   (chain_valid[k]),
      .up_ready   (chain_ready[k]),
      .up_data    (chain_data[k]),
      .down_valid (chain_valid[k+1]),
      .down_ready (chain_ready[k+1]),
      .down_data  (chain_data[k+1])
    );
  end

  assign chain_ready[SQ_STEPS] = !out_valid_r || out_tready;

  // Trigger decision and emergency override
  always_comb begin
    tail_side = chain_data[SQ_STEPS].side;
    if (tail_side.emerg) begin
      tail_cand    = EMERGENCY_ACC;
      tail_brake   = EMERGENCY_ACC;
      tail_trig    = '0;
      tail_precise = 1'b1;
    end else begin
      tail_trig    = 18'(chain_data[SQ_STEPS].root);
      tail_precise = tail_side.go && (18'(tail_side.speed) > tail_trig);
      tail_cand    = tail_side.acc;
      tail_brake   = tail_precise ? tail_side.acc : {1'b0, cfg_r.default_acc};
    end
  end

  assign out_valid_nxt = chain_ready[SQ_STEPS] ? chain_valid[SQ_STEPS] : out_valid_r;

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (chain_ready[SQ_STEPS] && chain_valid[SQ_STEPS]) begin
      brake_r   <= tail_brake;
      cand_r    <= tail_cand;
      trig_r    <= tail_trig;
      precise_r <= tail_precise;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {trig_r, cand_r, brake_r};
  assign out_tuser  = precise_r;

  // A precise stop commands the candidate rate
  a_precise_uses_candidate: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid_r && precise_r) |-> (brake_r == cand_r)
  ) else $error("precise stop with brake rate other than candidate");

  // Without a precise stop the default rate is commanded
  a_idle_uses_default: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid_r && !precise_r) |-> (brake_r == {1'b0, cfg_r.default_acc})
  ) else $error("default rate not commanded outside precise stop");

  // A rate at or below zero yields no trigger speed
  a_nonpos_rate_no_trigger: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid_r && (cand_r[10] || cand_r == 11'd0)) |-> (trig_r == 18'd0)
  ) else $error("trigger speed from a non-positive rate");

  // A stalled result holds its fields
  a_stall_holds: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_tdata) && $stable(precise_r))
  ) else $error("result changed while stalled");

endmodule

[hw/rtl/pbrs_front.sv]
// ----------------------------------------------------------------------------
// pbrs_front: brake rate candidate and radicand stages
// Three pipeline stages: speed term multiply, candidate rate selection with
// saturation, cap, rain clamp and rear override, then the 2*rate*distance
// product that feeds the square-root chain.
// ----------------------------------------------------------------------------
module pbrs_front import pbrs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     up_valid,
  output logic     up_ready,
  input  in_item_t up_item,
  output logic     down_valid,
  input  logic     down_ready,
  output sq_t      down_data
);

  // Stage 1 registers
  logic        s1_valid_r, s1_valid_nxt;
  logic [1:0]  s1_kind_r;
  logic [13:0] s1_speed_r;
  logic [23:0] s1_dist_r;
  logic        s1_go_r;
  logic        s1_rear_r;
  logic        s1_emerg_r;
  logic [13:0] s1_lin_r;

  // Stage 2 registers
  logic        s2_valid_r, s2_valid_nxt;
  logic [10:0] s2_acc_r;
  logic [13:0] s2_speed_r;
  logic [23:0] s2_dist_r;
  logic        s2_go_r;
  logic        s2_emerg_r;

  // Stage 3 registers
  logic        s3_valid_r, s3_valid_nxt;
  sq_t         s3_data_r;

  logic s1_ready, s2_ready, s3_ready;

  logic [29:0]        lin_prod;
  logic signed [15:0] off;
  logic signed [15:0] sum;
  logic signed [10:0] sat;
  logic signed [10:0] acc;
  logic [RAD_W-1:0]   rad;

  // Ready chain: a stage takes a request when empty or draining
  assign s3_ready = !s3_valid_r || down_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign up_ready = s1_ready;

  // Speed term of the linear rate
  assign lin_prod = 30'(cfg.para_a) * 30'(up_item.last_speed);

  assign s1_valid_nxt = s1_ready ? up_valid : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (s1_ready && up_valid) begin
      s1_kind_r  <= up_item.stop_kind;
      s1_speed_r <= up_item.last_speed;
      s1_dist_r  <= up_item.distance;
      s1_go_r    <= up_item.speed_target_ok & up_item.speed_train_ok &
                    ~up_item.stopped & ~cfg.mode_flags[MODE_IMM_STOP];
      s1_rear_r  <= up_item.coupled_rear;
      s1_emerg_r <= up_item.distance[23] || (up_item.distance == 24'd0);
      s1_lin_r   <= lin_prod[29:16];
    end
  end

  // Select the candidate rate by stop kind, then clamp and override
  always_comb begin
    case (s1_kind_r)
      KIND_AUTO_REVERSAL: off = 16'($signed(cfg.auto_reversal_b));
      KIND_REVERSAL:      off = 16'($signed(cfg.reversal_b));
      default:            off = 16'($signed(cfg.para_b));
    endcase
    sum = $signed({2'b00, s1_lin_r}) + off;
    if (sum > 16'sd1023) begin
      sat = 11'sd1023;
    end else if (sum < -16'sd1024) begin
      sat = -11'sd1024;
    end else begin
      sat = sum[10:0];
    end
    case (s1_kind_r)
      KIND_GARAGE: begin
        acc = $signed({1'b0, cfg.garage_acc});
      end
      KIND_NORMAL: begin
        if (sat > $signed({1'b0, cfg.origin_cap_acc})) begin
          acc = $signed({1'b0, cfg.origin_cap_acc});
        end else begin
          acc = sat;
        end
      end
      default: begin
        acc = sat;
      end
    endcase
    if (cfg.mode_flags[MODE_RAIN] && cfg.mode_flags[MODE_RAIN_PID] &&
        acc > $signed({1'b0, cfg.default_acc})) begin
      acc = $signed({1'b0, cfg.default_acc});
    end
    if (s1_rear_r && REAR_STOP_DIST > 25'sd0 &&
        $signed({s1_dist_r[23], s1_dist_r}) <= REAR_STOP_DIST &&
        REAR_STOP_ACC != 11'd0) begin
      acc = $signed(REAR_STOP_ACC);
    end
  end

  assign s2_valid_nxt = s2_ready ? s1_valid_r : s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      s2_acc_r   <= acc;
      s2_speed_r <= s1_speed_r;
      s2_dist_r  <= s1_dist_r;
      s2_go_r    <= s1_go_r;
      s2_emerg_r <= s1_emerg_r;
    end
  end

  // Radicand 2*rate*distance; zero for an emergency or a rate at or below zero
  always_comb begin
    if (!s2_emerg_r && !s2_acc_r[10] && (s2_acc_r != 11'd0)) begin
      rad = {RAD_W'(s2_dist_r[22:0]) * RAD_W'(s2_acc_r[9:0])} << 1;
    end else begin
      rad = '0;
    end
  end

  assign s3_valid_nxt = s3_ready ? s2_valid_r : s3_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s3_valid_nxt;
    end
    if (s3_ready && s2_valid_r) begin
      s3_data_r.x          <= rad;
      s3_data_r.rem        <= '0;
      s3_data_r.root       <= '0;
      s3_data_r.side.acc   <= s2_acc_r;
      s3_data_r.side.speed <= s2_speed_r;
      s3_data_r.side.go    <= s2_go_r;
      s3_data_r.side.emerg <= s2_emerg_r;
    end
  end

  assign down_valid = s3_valid_r;
  assign down_data  = s3_data_r;

endmodule

[hw/rtl/pbrs_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// pbrs_sqrt_cell: one digit of the integer square root
// Brings in the next two radicand bits, tries the next root bit and hands the
// partial root, remainder and side data to the neighbor cell.
// ----------------------------------------------------------------------------
module pbrs_sqrt_cell import pbrs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  sq_t  up_data,
  output logic down_valid,
  input  logic down_ready,
  output sq_t  down_data
);

  logic             valid_r, valid_nxt;
  sq_t              data_r, data_nxt;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  // Try the next root bit against the shifted remainder
  always_comb begin
    rem_sh = {up_data.rem[REM_W-3:0], up_data.x[RAD_W-1 -: 2]};
    trial  = {1'b0, up_data.root, 2'b01};
    fits   = (rem_sh >= trial);
    data_nxt.x    = {up_data.x[RAD_W-3:0], 2'b00};
    data_nxt.rem  = fits ? (rem_sh - trial) : rem_sh;
    data_nxt.root = {up_data.root[ROOT_W-2:0], fits};
    data_nxt.side = up_data.side;
  end

  assign up_ready  = !valid_r || down_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  // Advance when the neighbor takes the request or this cell is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign down_valid = valid_r;
  assign down_data  = data_r;

endmodule
